FILE: design/assert_macros.svh
// Assertion macros shared by the xorshift1024* generator RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

FILE: design/xs1024_pkg.sv
// Package for the xorshift1024* generator: sizes, codes, jump table,
// controller state type and the command and status structs. No dependencies.
package xs1024_pkg;

   localparam int WORD_W      = 64;
   localparam int HALF_W      = WORD_W / 2;
   localparam int STATE_WORDS = 16;
   localparam int JUMP_WORDS  = 16;
   localparam int JUMP_STEPS  = JUMP_WORDS * WORD_W;
   localparam int JUMP_CNT_W  = $clog2(JUMP_STEPS);
   localparam int BIT_SEL_W   = $clog2(WORD_W);
   localparam int WORD_SEL_W  = $clog2(JUMP_WORDS);
   localparam int FILL_CNT_W  = $clog2(STATE_WORDS);
   localparam int SHIFT_W     = 6;
   localparam int CSR_IDX_W   = 2;
   localparam int REQ_TYPE_W  = 2;

   // Multiplier of the xorshift64* chain used when reseeding.
   localparam logic [WORD_W-1:0] SEED_MULT = 64'h2545F4914F6CDD1D;

   // Register reset values.
   localparam logic [SHIFT_W-1:0] SHIFT_LEFT_RST = 6'd31;
   localparam logic [SHIFT_W-1:0] SHIFT_RNEW_RST = 6'd11;
   localparam logic [SHIFT_W-1:0] SHIFT_ROLD_RST = 6'd30;
   localparam logic [WORD_W-1:0]  OUT_MULT_RST   = 64'd1181783497276652981;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_LEFT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_RNEW = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_ROLD = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_MULT   = 2'd3;

   // Request kinds; the fourth code is ignored.
   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_GENERATE = 2'd0,
      REQ_RESEED   = 2'd1,
      REQ_JUMP     = 2'd2
   } req_kind_type;

   // Jump polynomial for a 2^512 step advance.
   localparam logic [WORD_W-1:0] JUMP_POLY [JUMP_WORDS] = '{
      64'h84242f96eca9c41d, 64'ha3c65b8776f96855, 64'h5b34a39f070b5837,
      64'h4489affce4f31a1e, 64'h2ffeeb0a48316f40, 64'hdc2d9891fe68c022,
      64'h3659132bb12fea70, 64'haac17d8efa43cab8, 64'hc4cb815590989b13,
      64'h5ee975283d71c93b, 64'h691548c86c1bd540, 64'h7910c41d10a1e6a5,
      64'h0b5fc64563b3e2a8, 64'h047f7684e9fc949d, 64'hb99181f2d8f685ca,
      64'h284600e3f30e38c3
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GEN_WAIT,
      ST_SEED_MIX,
      ST_SEED_WAIT,
      ST_JUMP_STEP,
      ST_JUMP_LOAD,
      ST_FINISH
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic advance;        // one generator step on the word store
      logic push_seed;      // shift the cleaned seed into the store
      logic push_prod;      // shift the multiplier product into the store
      logic mul_start_gen;  // multiply the new word by the output multiplier
      logic mul_start_seed; // multiply the mixed last word by the seed multiplier
      logic acc_clear;      // zero the jump accumulator
      logic acc_xor;        // fold the current store into the accumulator
      logic load_acc;       // copy the accumulator into the store
      logic count_clear;    // zero the step count
      logic out_load;       // capture a result into the output register
      logic out_word_valid; // the captured result carries a generated word
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic mul_done;       // multiplier product is final this cycle
   } dp_status_type;

   // xorshift64 mixing of a reseed word before its multiplication.
   function automatic logic [WORD_W-1:0] seed_mix(input logic [WORD_W-1:0] s);
      logic [WORD_W-1:0] t;
      t = s ^ (s >> 12);
      t = t ^ (t << 25);
      t = t ^ (t >> 27);
      return t;
   endfunction

endpackage

FILE: design/xs1024_mul.sv
// Shared 64x64 multiplier keeping the low 64 bits, one 32x32 product a cycle.
// Depends on xs1024_pkg for widths.
module xs1024_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [xs1024_pkg::WORD_W-1:0] op_a,
   input  logic [xs1024_pkg::WORD_W-1:0] op_b,
   output logic                          done,
   output logic [xs1024_pkg::WORD_W-1:0] product
);

   localparam int HW = xs1024_pkg::HALF_W;

   // Phase codes: low product, then the two cross products.
   localparam logic [1:0] PH_LOW     = 2'd0;
   localparam logic [1:0] PH_CROSS_A = 2'd1;
   localparam logic [1:0] PH_CROSS_B = 2'd2;

   logic [xs1024_pkg::WORD_W-1:0] a_ff, a_in, b_ff, b_in, prod_ff, prod_in;
   logic [1:0]                    phase_ff, phase_in;
   logic                          busy_ff, busy_in, done_ff, done_in;
   logic [HW-1:0]                 mul_x, mul_y;
   logic [2*HW-1:0]               mul_p;

   // Operand selection for the single 32x32 multiplier.
   always_comb begin
      mul_x = (phase_ff == PH_CROSS_A) ? a_ff[2*HW-1:HW] : a_ff[HW-1:0];
      mul_y = (phase_ff == PH_CROSS_B) ? b_ff[2*HW-1:HW] : b_ff[HW-1:0];
      mul_p = mul_x * mul_y;
   end

   // Phase sequencing and partial product accumulation.
   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      prod_in  = prod_ff;
      phase_in = phase_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         a_in     = op_a;
         b_in     = op_b;
         phase_in = PH_LOW;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         case (phase_ff)
            PH_LOW: begin
               prod_in  = mul_p;
               phase_in = PH_CROSS_A;
            end
            PH_CROSS_A: begin
               prod_in  = {prod_ff[2*HW-1:HW] + mul_p[HW-1:0], prod_ff[HW-1:0]};
               phase_in = PH_CROSS_B;
            end
            PH_CROSS_B: begin
               prod_in  = {prod_ff[2*HW-1:HW] + mul_p[HW-1:0], prod_ff[HW-1:0]};
               phase_in = PH_LOW;
               busy_in  = 1'b0;
               done_in  = 1'b1;
            end
            default: begin
               phase_in = PH_LOW;
               busy_in  = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LOW;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

FILE: design/xs1024_datapath.sv
// Datapath of the xorshift1024* generator: word store, jump accumulator,
// step count, registers, multiplier and output register. Uses xs1024_pkg.
module xs1024_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   input  logic [xs1024_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [xs1024_pkg::WORD_W-1:0]    csr_data,
   input  logic [xs1024_pkg::WORD_W-1:0]    seed_value,
   input  xs1024_pkg::ctrl_cmd_type         cmd,
   output xs1024_pkg::dp_status_type        status,
   output logic [xs1024_pkg::WORD_W-1:0]    out_word,
   output logic                             out_flag,
   output logic [xs1024_pkg::WORD_W-1:0]    out_count
);

   localparam int W  = xs1024_pkg::WORD_W;
   localparam int SW = xs1024_pkg::STATE_WORDS;

   logic [xs1024_pkg::SHIFT_W-1:0] shl_ff, shl_in, srn_ff, srn_in, sro_ff, sro_in;
   logic [W-1:0]  mult_ff, mult_in;
   logic [W-1:0]  store_ff [SW];
   logic [W-1:0]  store_in [SW];
   logic [W-1:0]  acc_ff [SW];
   logic [W-1:0]  acc_in [SW];
   logic [W-1:0]  count_ff, count_in;
   logic [W-1:0]  out_word_ff, out_word_in, out_count_ff;
   logic          out_flag_ff;
   logic [W-1:0]  cur, nxt, mixed, adv_word, seed_fix;
   logic [W-1:0]  mul_a, mul_b, mul_prod;
   logic          mul_done;

   // Configuration registers.
   always_comb begin
      shl_in  = shl_ff;
      srn_in  = srn_ff;
      sro_in  = sro_ff;
      mult_in = mult_ff;
      if (csr_valid) begin
         case (csr_index)
            xs1024_pkg::CSR_SHIFT_LEFT: shl_in  = csr_data[xs1024_pkg::SHIFT_W-1:0];
            xs1024_pkg::CSR_SHIFT_RNEW: srn_in  = csr_data[xs1024_pkg::SHIFT_W-1:0];
            xs1024_pkg::CSR_SHIFT_ROLD: sro_in  = csr_data[xs1024_pkg::SHIFT_W-1:0];
            xs1024_pkg::CSR_OUT_MULT:   mult_in = csr_data;
            default: ;
         endcase
      end
   end

   // One generator step. The store is kept rotated so that entry 0 is the
   // current word and entry 1 the next one.
   always_comb begin
      cur      = store_ff[0];
      nxt      = store_ff[1];
      mixed    = nxt ^ (nxt << shl_ff);
      adv_word = mixed ^ (mixed >> srn_ff) ^ cur ^ (cur >> sro_ff);
      seed_fix = (seed_value == '0) ? W'(1) : seed_value;
   end

   // Word store update: rotate on a step, shift in from the top on reseed,
   // or take the accumulator at the end of a jump.
   always_comb begin
      for (int i = 0; i < SW; i++) begin
         store_in[i] = store_ff[i];
      end
      if (cmd.load_acc) begin
         for (int i = 0; i < SW; i++) begin
            store_in[i] = acc_ff[i];
         end
      end else if (cmd.advance) begin
         for (int i = 0; i < SW; i++) begin
            store_in[i] = store_ff[(i + 1) % SW];
         end
         store_in[0] = adv_word;
      end else if (cmd.push_seed || cmd.push_prod) begin
         for (int i = 0; i < SW; i++) begin
            store_in[i] = store_ff[(i + 1) % SW];
         end
         store_in[SW-1] = cmd.push_seed ? seed_fix : mul_prod;
      end
   end

   // Jump accumulator lanes, each folding in its own store entry.
   always_comb begin
      for (int i = 0; i < SW; i++) begin
         if (cmd.acc_clear) begin
            acc_in[i] = '0;
         end else if (cmd.acc_xor) begin
            acc_in[i] = acc_ff[i] ^ store_ff[i];
         end else begin
            acc_in[i] = acc_ff[i];
         end
      end
   end

   // Step count.
   always_comb begin
      if (cmd.count_clear) begin
         count_in = '0;
      end else if (cmd.advance) begin
         count_in = count_ff + W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   // Multiplier operands: output scrambling or the reseed chain.
   always_comb begin
      mul_a = cmd.mul_start_gen ? adv_word : xs1024_pkg::seed_mix(store_ff[SW-1]);
      mul_b = cmd.mul_start_gen ? mult_ff : xs1024_pkg::SEED_MULT;
   end

   xs1024_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start_gen || cmd.mul_start_seed),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_prod)
   );

   assign status.mul_done = mul_done;

   // Result word is zero unless the item was a generate request.
   assign out_word_in = cmd.out_word_valid ? mul_prod : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         shl_ff   <= xs1024_pkg::SHIFT_LEFT_RST;
         srn_ff   <= xs1024_pkg::SHIFT_RNEW_RST;
         sro_ff   <= xs1024_pkg::SHIFT_ROLD_RST;
         mult_ff  <= xs1024_pkg::OUT_MULT_RST;
         count_ff <= '0;
         for (int i = 0; i < SW; i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         shl_ff   <= shl_in;
         srn_ff   <= srn_in;
         sro_ff   <= sro_in;
         mult_ff  <= mult_in;
         count_ff <= count_in;
         for (int i = 0; i < SW; i++) begin
            store_ff[i] <= store_in[i];
         end
      end
   end

   // Accumulator and output payload need no reset.
   always_ff @(posedge clock) begin
      for (int i = 0; i < SW; i++) begin
         acc_ff[i] <= acc_in[i];
      end
      if (cmd.out_load) begin
         out_word_ff  <= out_word_in;
         out_flag_ff  <= cmd.out_word_valid;
         out_count_ff <= count_ff;
      end
   end

   assign out_word  = out_word_ff;
   assign out_flag  = out_flag_ff;
   assign out_count = out_count_ff;

endmodule

FILE: design/xs1024_ctrl.sv
// Controller of the xorshift1024* generator: request decode, reseed and jump
// sequencing, and result handshake. Uses xs1024_pkg and assert_macros.svh.
`include "assert_macros.svh"

module xs1024_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [xs1024_pkg::REQ_TYPE_W-1:0] req_type,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  xs1024_pkg::dp_status_type         status,
   output xs1024_pkg::ctrl_cmd_type          cmd
);

   localparam int CW = xs1024_pkg::JUMP_CNT_W;
   localparam int FW = xs1024_pkg::FILL_CNT_W;

   xs1024_pkg::ctrl_state_type state_ff, state_in;
   logic [CW-1:0] jump_cnt_ff, jump_cnt_in;
   logic [FW-1:0] words_left_ff, words_left_in;
   logic          gen_flag_ff, gen_flag_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          req_fire, jump_bit, out_free;
   logic [xs1024_pkg::WORD_W-1:0] poly_word;

   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Jump polynomial bit for the current step.
   always_comb begin
      poly_word = xs1024_pkg::JUMP_POLY[jump_cnt_ff[CW-1:xs1024_pkg::BIT_SEL_W]];
      jump_bit  = poly_word[jump_cnt_ff[xs1024_pkg::BIT_SEL_W-1:0]];
   end

   // Next state and commands.
   always_comb begin
      state_in      = state_ff;
      jump_cnt_in   = jump_cnt_ff;
      words_left_in = words_left_ff;
      gen_flag_in   = gen_flag_ff;
      req_tready    = 1'b0;
      cmd           = '0;
      case (state_ff)
         xs1024_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               gen_flag_in = 1'b0;
               case (req_type)
                  xs1024_pkg::REQ_GENERATE: begin
                     cmd.advance       = 1'b1;
                     cmd.mul_start_gen = 1'b1;
                     gen_flag_in       = 1'b1;
                     state_in          = xs1024_pkg::ST_GEN_WAIT;
                  end
                  xs1024_pkg::REQ_RESEED: begin
                     cmd.push_seed   = 1'b1;
                     cmd.count_clear = 1'b1;
                     words_left_in   = FW'(xs1024_pkg::STATE_WORDS - 1);
                     state_in        = xs1024_pkg::ST_SEED_MIX;
                  end
                  xs1024_pkg::REQ_JUMP: begin
                     cmd.acc_clear = 1'b1;
                     jump_cnt_in   = '0;
                     state_in      = xs1024_pkg::ST_JUMP_STEP;
                  end
                  default: begin
                     state_in = xs1024_pkg::ST_FINISH;
                  end
               endcase
            end
         end
         xs1024_pkg::ST_GEN_WAIT: begin
            if (status.mul_done) begin
               state_in = xs1024_pkg::ST_FINISH;
            end
         end
         xs1024_pkg::ST_SEED_MIX: begin
            cmd.mul_start_seed = 1'b1;
            state_in           = xs1024_pkg::ST_SEED_WAIT;
         end
         xs1024_pkg::ST_SEED_WAIT: begin
            if (status.mul_done) begin
               cmd.push_prod = 1'b1;
               words_left_in = words_left_ff - FW'(1);
               state_in      = (words_left_ff == FW'(1)) ? xs1024_pkg::ST_FINISH
                                                         : xs1024_pkg::ST_SEED_MIX;
            end
         end
         xs1024_pkg::ST_JUMP_STEP: begin
            cmd.advance = 1'b1;
            cmd.acc_xor = jump_bit;
            jump_cnt_in = jump_cnt_ff + CW'(1);
            if (jump_cnt_ff == CW'(xs1024_pkg::JUMP_STEPS - 1)) begin
               state_in = xs1024_pkg::ST_JUMP_LOAD;
            end
         end
         xs1024_pkg::ST_JUMP_LOAD: begin
            cmd.load_acc = 1'b1;
            state_in     = xs1024_pkg::ST_FINISH;
         end
         xs1024_pkg::ST_FINISH: begin
            if (out_free) begin
               cmd.out_load       = 1'b1;
               cmd.out_word_valid = gen_flag_ff;
               state_in           = xs1024_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = xs1024_pkg::ST_IDLE;
         end
      endcase
   end

   // Result valid: set on capture, cleared when the item is taken.
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= xs1024_pkg::ST_IDLE;
         jump_cnt_ff   <= '0;
         words_left_ff <= '0;
         gen_flag_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         jump_cnt_ff   <= jump_cnt_in;
         words_left_ff <= words_left_in;
         gen_flag_ff   <= gen_flag_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   // The multiplier finishes only while the controller waits for it.
   `ASSERT_IMPLIES(a_mul_done_waited, clock, reset, status.mul_done,
      (state_ff == xs1024_pkg::ST_GEN_WAIT) || (state_ff == xs1024_pkg::ST_SEED_WAIT))

   // A reseed in progress always has words left to fill.
   `ASSERT_IMPLIES(a_seed_words_left, clock, reset,
      (state_ff == xs1024_pkg::ST_SEED_MIX) || (state_ff == xs1024_pkg::ST_SEED_WAIT),
      words_left_ff != '0)

   // A jump request starts its step sequence at the first polynomial bit.
   `ASSERT_NEXT(a_jump_starts_at_zero, clock, reset,
      req_fire && (req_type == xs1024_pkg::REQ_JUMP),
      (state_ff == xs1024_pkg::ST_JUMP_STEP) && (jump_cnt_ff == '0))

   // A finished result waits while the previous one is still held.
   `ASSERT_NEXT(a_finish_holds, clock, reset,
      (state_ff == xs1024_pkg::ST_FINISH) && rsp_valid_ff && !rsp_tready,
      (state_ff == xs1024_pkg::ST_FINISH) && rsp_valid_ff)

endmodule

FILE: design/xorshift1024_star_generator.sv
// Top level of the xorshift1024* generator.
// Instantiates xs1024_ctrl and xs1024_datapath; uses xs1024_pkg.
//
// Usage:
//   The req channel takes one item per request: req_tuser selects generate,
//   reseed or jump, and req_tdata carries the seed for reseed requests.
//   Every request gives exactly one item on the rsp channel with the random
//   word (zero unless generated), a word-valid flag and the step count. The
//   csr channel writes the shift amounts and the output multiplier; it is
//   always ready and is to be written only while the block is idle (unchecked).
// Sequence:
//   A generate item is accepted, its 64-bit product is formed by a shared
//   32x32 multiplier from its low and cross partial products, and the result
//   is then captured; the next request can be taken in the cycle the result
//   becomes valid. A reseed runs the 15-word fill through the same multiplier.
//   A jump takes 1024 steps at one a cycle, then loads the accumulator and
//   hands the result off.
// Reset clears the store, the count and the registers to their defaults.
// A stalled receiver holds the result in the output register; one more
// item is accepted and worked, then it waits until the result is taken.
module xorshift1024_star_generator (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request channel.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [xs1024_pkg::WORD_W-1:0]        req_tdata,  // [63:0] seed_value
   input  logic [xs1024_pkg::REQ_TYPE_W-1:0]    req_tuser,  // [1:0] req_type
   // Result channel.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [2*xs1024_pkg::WORD_W-1:0]      rsp_tdata,  // [63:0] random_word,
                                                            // [127:64] words_generated
   output logic [0:0]                           rsp_tuser,  // [0] word_valid
   // Configuration write channel.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [xs1024_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [xs1024_pkg::WORD_W-1:0]        csr_data
);

   xs1024_pkg::ctrl_cmd_type      cmd;
   xs1024_pkg::dp_status_type     status;
   logic [xs1024_pkg::WORD_W-1:0] out_word, out_count;
   logic                          out_flag;

   // Registers are plain flops, to be written only in idle cycles (unchecked).
   assign csr_ready = 1'b1;

   xs1024_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_type   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   xs1024_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .seed_value (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .out_word   (out_word),
      .out_flag   (out_flag),
      .out_count  (out_count)
   );

   // Pack the result item.
   assign rsp_tdata = {out_count, out_word};
   assign rsp_tuser = out_flag;

endmodule

FILE: bench/tb.sv
// Self-checking bench for the xorshift1024* generator: a queue-fed driver,
// a posedge monitor with an in-bench predictor of the word store, and phased idling.
// Depends on xs1024_pkg and xorshift1024_star_generator.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Package constants used throughout the bench.
   localparam int WORD_W      = xs1024_pkg::WORD_W;
   localparam int REQ_TYPE_W  = xs1024_pkg::REQ_TYPE_W;
   localparam int CSR_IDX_W   = xs1024_pkg::CSR_IDX_W;
   localparam int SHIFT_W     = xs1024_pkg::SHIFT_W;
   localparam int STATE_WORDS = xs1024_pkg::STATE_WORDS;
   localparam int JUMP_WORDS  = xs1024_pkg::JUMP_WORDS;
   localparam logic [WORD_W-1:0] SEED_MULT = xs1024_pkg::SEED_MULT;
   localparam logic [WORD_W-1:0] JUMP_POLY [JUMP_WORDS] = xs1024_pkg::JUMP_POLY;
   localparam logic [SHIFT_W-1:0] SHIFT_LEFT_RST = xs1024_pkg::SHIFT_LEFT_RST;
   localparam logic [SHIFT_W-1:0] SHIFT_RNEW_RST = xs1024_pkg::SHIFT_RNEW_RST;
   localparam logic [SHIFT_W-1:0] SHIFT_ROLD_RST = xs1024_pkg::SHIFT_ROLD_RST;
   localparam logic [WORD_W-1:0]  OUT_MULT_RST   = xs1024_pkg::OUT_MULT_RST;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_LEFT = xs1024_pkg::CSR_SHIFT_LEFT;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_RNEW = xs1024_pkg::CSR_SHIFT_RNEW;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_ROLD = xs1024_pkg::CSR_SHIFT_ROLD;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_MULT   = xs1024_pkg::CSR_OUT_MULT;
   localparam logic [REQ_TYPE_W-1:0] REQ_GENERATE = xs1024_pkg::REQ_GENERATE;
   localparam logic [REQ_TYPE_W-1:0] REQ_RESEED   = xs1024_pkg::REQ_RESEED;
   localparam logic [REQ_TYPE_W-1:0] REQ_JUMP     = xs1024_pkg::REQ_JUMP;

   // The fourth request code, which the block ignores.
   localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;
   localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};

   typedef struct {
      logic [REQ_TYPE_W-1:0] kind;
      logic [WORD_W-1:0]     seed;
   } request_item_type;

   typedef struct {
      logic [WORD_W-1:0] word;
      logic              flag;
      logic [WORD_W-1:0] count;
   } word_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [WORD_W-1:0]         req_tdata = '0;
   logic [REQ_TYPE_W-1:0]     req_tuser = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [2*WORD_W-1:0]       rsp_tdata;
   logic [0:0]                rsp_tuser;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [WORD_W-1:0]         csr_data = '0;

   // Pending requests, expected results and the idling controls.
   request_item_type pending_reqs[$];
   word_result_type  expected_words[$];
   request_item_type next_req;
   logic        req_taken = 1'b0;
   int          sender_idle_pct = 0;
   int          receiver_stall_pct = 0;
   int          mismatch_count = 0;

   // Predictor copy of the generator state and its registers.
   logic [WORD_W-1:0]  mix_store [STATE_WORDS];
   logic [3:0]         mix_pos;
   logic [WORD_W-1:0]  step_total;
   logic [SHIFT_W-1:0] cfg_shl;
   logic [SHIFT_W-1:0] cfg_shr_new;
   logic [SHIFT_W-1:0] cfg_shr_old;
   logic [WORD_W-1:0]  cfg_mult;

   xorshift1024_star_generator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2ns clock = ~clock;

   // One generator step: mix the current and next words, return the scrambled word.
   function automatic logic [WORD_W-1:0] advance_store();
      logic [WORD_W-1:0] cur;
      logic [WORD_W-1:0] nxt;
      step_total = step_total + 1'b1;
      cur = mix_store[mix_pos];
      mix_pos = mix_pos + 1'b1;
      nxt = mix_store[mix_pos];
      nxt = nxt ^ (nxt << cfg_shl);
      nxt = nxt ^ (nxt >> cfg_shr_new) ^ cur ^ (cur >> cfg_shr_old);
      mix_store[mix_pos] = nxt;
      return nxt * cfg_mult;
   endfunction

   // Reload the store from a seed through a xorshift64* chain.
   function automatic void reseed_store(input logic [WORD_W-1:0] seed);
      logic [WORD_W-1:0] s;
      mix_store[0] = (seed == '0) ? 64'd1 : seed;
      for (int i = 1; i < STATE_WORDS; i++) begin
         s = mix_store[i-1];
         s = s ^ (s >> 12);
         s = s ^ (s << 25);
         s = s ^ (s >> 27);
         mix_store[i] = s * SEED_MULT;
      end
      mix_pos = '0;
      step_total = '0;
   endfunction

   // Advance by the jump polynomial, folding the store into an accumulator.
   function automatic void jump_store();
      logic [WORD_W-1:0] acc [STATE_WORDS];
      logic [3:0]        idx;
      for (int j = 0; j < STATE_WORDS; j++) acc[j] = '0;
      for (int i = 0; i < JUMP_WORDS; i++) begin
         for (int b = 0; b < WORD_W; b++) begin
            if (JUMP_POLY[i][b]) begin
               for (int j = 0; j < STATE_WORDS; j++) begin
                  idx = mix_pos + 4'(j);
                  acc[j] = acc[j] ^ mix_store[idx];
               end
            end
            void'(advance_store());
         end
      end
      for (int j = 0; j < STATE_WORDS; j++) begin
         idx = mix_pos + 4'(j);
         mix_store[idx] = acc[j];
      end
   endfunction

   function automatic word_result_type predict_request(input logic [REQ_TYPE_W-1:0] kind,
                                                       input logic [WORD_W-1:0] seed);
      word_result_type res;
      res.word = '0;
      res.flag = 1'b0;
      case (kind)
         REQ_GENERATE: begin
            res.word = advance_store();
            res.flag = 1'b1;
         end
         REQ_RESEED: reseed_store(seed);
         REQ_JUMP: jump_store();
         default: ;
      endcase
      res.count = step_total;
      return res;
   endfunction

   task automatic report_mismatch(input string field, input logic [WORD_W-1:0] got,
                                  input logic [WORD_W-1:0] want);
      $display("mismatch in %s at %0t: got %h, expected %h", field, $realtime, got, want);
      mismatch_count++;
   endtask

   // Driver: present the next pending item once the previous one was taken.
   always @(negedge clock) begin
      if (!req_tvalid || req_taken) begin
         if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            next_req = pending_reqs.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= next_req.seed;
            req_tuser <= next_req.kind;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Monitor: track register writes, predict accepted items, check results.
   always @(posedge clock) begin
      word_result_type want;
      req_taken <= req_tvalid && req_tready;
      if (reset) begin
         for (int i = 0; i < STATE_WORDS; i++) mix_store[i] = '0;
         mix_pos = '0;
         step_total = '0;
         cfg_shl = SHIFT_LEFT_RST;
         cfg_shr_new = SHIFT_RNEW_RST;
         cfg_shr_old = SHIFT_ROLD_RST;
         cfg_mult = OUT_MULT_RST;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SHIFT_LEFT: cfg_shl = csr_data[SHIFT_W-1:0];
               CSR_SHIFT_RNEW: cfg_shr_new = csr_data[SHIFT_W-1:0];
               CSR_SHIFT_ROLD: cfg_shr_old = csr_data[SHIFT_W-1:0];
               CSR_OUT_MULT: cfg_mult = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) expected_words.push_back(predict_request(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               report_mismatch("result with nothing expected", rsp_tdata[WORD_W-1:0], '0);
            end else begin
               want = expected_words.pop_front();
               if (rsp_tdata[WORD_W-1:0] !== want.word)
                  report_mismatch("random_word", rsp_tdata[WORD_W-1:0], want.word);
               if (rsp_tuser[0] !== want.flag)
                  report_mismatch("word_valid", 64'(rsp_tuser[0]), 64'(want.flag));
               if (rsp_tdata[2*WORD_W-1:WORD_W] !== want.count)
                  report_mismatch("words_generated", rsp_tdata[2*WORD_W-1:WORD_W], want.count);
            end
         end
      end
   end

   // Wait until every item has been sent and answered, then let the block settle.
   task automatic wait_idle();
      while (pending_reqs.size() > 0 || req_tvalid || expected_words.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Shift values carry random upper bits, which the block must drop.
   task automatic load_settings(input logic [SHIFT_W-1:0] shl, input logic [SHIFT_W-1:0] shrn,
                                input logic [SHIFT_W-1:0] shro, input logic [WORD_W-1:0] mult);
      logic [WORD_W-1:0] noise;
      wait_idle();
      noise = {$urandom, $urandom};
      write_csr(CSR_SHIFT_LEFT, {noise[WORD_W-1:SHIFT_W], shl});
      noise = {$urandom, $urandom};
      write_csr(CSR_SHIFT_RNEW, {noise[WORD_W-1:SHIFT_W], shrn});
      noise = {$urandom, $urandom};
      write_csr(CSR_SHIFT_ROLD, {noise[WORD_W-1:SHIFT_W], shro});
      write_csr(CSR_OUT_MULT, mult);
   endtask

   task automatic queue_req(input logic [REQ_TYPE_W-1:0] kind, input logic [WORD_W-1:0] seed);
      request_item_type item;
      item.kind = kind;
      item.seed = seed;
      pending_reqs.push_back(item);
   endtask

   // Mostly generate requests, with occasional reseeds, jumps and unused codes.
   task automatic queue_random(input int count);
      int                    sent;
      int                    pick;
      logic [REQ_TYPE_W-1:0] kind;
      logic [WORD_W-1:0]     seed;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 80) kind = REQ_GENERATE;
         else if (pick < 87) kind = REQ_RESEED;
         else if (pick < 91) kind = REQ_JUMP;
         else kind = REQ_UNUSED;
         pick = $urandom_range(99);
         if (pick < 5) seed = '0;
         else if (pick < 10) seed = ALL_ONES;
         else seed = {$urandom, $urandom};
         queue_req(kind, seed);
         sent++;
      end
   endtask

   // One random phase, with a full drain halfway through.
   task automatic run_phase(input int idle_pct, input int stall_pct);
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      queue_random(50);
      wait_idle();
      queue_random(50);
   endtask

   // Stimulus: directed checks first, then random phases under several settings.
   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Unseeded store, ignored code, zero and all-ones seeds, jumps.
      queue_req(REQ_GENERATE, ALL_ONES);
      queue_req(REQ_GENERATE, '0);
      queue_req(REQ_JUMP, '0);
      queue_req(REQ_UNUSED, ALL_ONES);
      queue_req(REQ_RESEED, '0);
      queue_req(REQ_GENERATE, '0);
      queue_req(REQ_GENERATE, '0);
      queue_req(REQ_GENERATE, '0);
      queue_req(REQ_RESEED, ALL_ONES);
      queue_req(REQ_GENERATE, '0);
      queue_req(REQ_JUMP, ALL_ONES);
      queue_req(REQ_GENERATE, '0);
      queue_req(REQ_GENERATE, '0);
      queue_req(REQ_UNUSED, '0);
      queue_req(REQ_RESEED, {$urandom, $urandom});
      queue_req(REQ_GENERATE, '0);

      // Largest shifts and multiplier; the registers must survive a reseed.
      load_settings(6'd63, 6'd63, 6'd63, ALL_ONES);
      queue_req(REQ_GENERATE, '0);
      queue_req(REQ_RESEED, {$urandom, $urandom});
      queue_req(REQ_GENERATE, '0);
      queue_req(REQ_JUMP, '0);
      queue_req(REQ_GENERATE, '0);

      load_settings(SHIFT_LEFT_RST, SHIFT_RNEW_RST, SHIFT_ROLD_RST, OUT_MULT_RST);
      run_phase(0, 0);
      load_settings(6'($urandom), 6'($urandom), 6'($urandom), {$urandom, $urandom} | 64'd1);
      run_phase(82, 0);
      load_settings(6'd0, 6'd0, 6'd0, '0);
      run_phase(0, 82);
      load_settings(6'($urandom), 6'($urandom), 6'($urandom), {$urandom, $urandom});
      run_phase(25, 25);

      wait_idle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("xorshift1024_star_generator regression: pass");
      end else begin
         $display("xorshift1024_star_generator regression: fail");
      end
      $finish;
   end

   // Watchdog far beyond the slowest correct run.
   initial begin
      #4_000_000;
      $display("xorshift1024_star_generator regression: fail");
      $finish;
   end

endmodule
